// ===== rtl/core/lbp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lbp_pkg: shared types and constants for the 3x3 LBP stream
// Pixel and code widths, config register map, defaults, helper functions.
// ----------------------------------------------------------------------------
package lbp_pkg;

  localparam int PIX_W          = 8;
  localparam int CODE_W         = 8;
  localparam int FW_W           = 11;   // frame_width register width
  localparam int FH_W           = 16;   // frame_height register width
  localparam int CFG_W          = 16;   // widest register
  localparam int CFG_IDX_W      = 1;
  localparam int DEF_MAX_WIDTH  = 1024;

  localparam logic [FW_W-1:0] DEF_FRAME_WIDTH  = FW_W'(640);
  localparam logic [FH_W-1:0] DEF_FRAME_HEIGHT = FH_W'(480);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_WIDTH  = 1'b0,
    CFG_FRAME_HEIGHT = 1'b1
  } cfg_reg_t;

  // Per-pixel side info carried from the counters to the code stage
  typedef struct packed {
    logic emit;       // center is interior, a code comes out
    logic frame_end;  // last code of the frame
  } lbp_tag_t;

  // Last row index, heights below 3 act as 3
  function automatic logic [FH_W-1:0] last_row_of(input logic [FH_W-1:0] h);
    logic [FH_W-1:0] r;
    if (h < FH_W'(3)) begin
      r = FH_W'(2);
    end else begin
      r = h - FH_W'(1);
    end
    return r;
  endfunction

  function automatic logic brighter(input logic [PIX_W-1:0] nb,
                                    input logic [PIX_W-1:0] ctr);
    return nb > ctr;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/lbp_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lbp_if: stream channels of the LBP block
// Pixel channel and code channel, each valid/ready with payload.
// ----------------------------------------------------------------------------
interface lbp_pix_if;
  import lbp_pkg::*;

  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] brightness;

  modport source (output valid, output brightness, input ready);
  modport sink   (input valid, input brightness, output ready);
endinterface

interface lbp_code_if;
  import lbp_pkg::*;

  logic              valid;
  logic              ready;
  logic [CODE_W-1:0] pattern_code;
  logic              frame_end;

  modport source (output valid, output pattern_code, output frame_end, input ready);
  modport sink   (input valid, input pattern_code, input frame_end, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/lbp_3x3_pattern_stream.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lbp_3x3_pattern_stream: 3x3 local binary pattern over a pixel stream
//
// Usage:
//  - in_pix carries one brightness value per transfer, raster order.
//  - out_code carries one 8-bit pattern code per interior pixel, in raster
//    order of the centers; frame_end marks the last code of a frame.
//    Border pixels are consumed and give no transfer on out_code.
//  - cfg port: cfg_we with cfg_idx selects frame_width (0) or
//    frame_height (1). Any write restarts the frame at pixel (0,0).
//    Width is clamped to 3..MAX_WIDTH, height to at least 3.
//  - Path: after the transfer of the pixel below-right of its center,
//    a code passes stage 1 (with line store read), then the code
//    register, and shows on out_code; it can transfer at the following edge.
//  - Throughput: one pixel per cycle while out_code is not stalled, set by
//    the single-port read plus single-port write of the line store each cycle.
//  - Reset: geometry goes to 640x480, counters and window clear, both
//    stages empty. Line store contents are not cleared; they are always
//    written before a code reads them.
//  - Receiver stall: the code register holds; the stage behind it keeps
//    one pixel, then in_pix.ready drops until out_code moves again.
// ----------------------------------------------------------------------------
module lbp_3x3_pattern_stream #(
  parameter int MAX_WIDTH = lbp_pkg::DEF_MAX_WIDTH
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_we,
  input  wire logic [lbp_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  wire logic [lbp_pkg::CFG_W-1:0]      cfg_wdata,
  lbp_pix_if.sink                             in_pix,
  lbp_code_if.source                          out_code
);
  import lbp_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);

  logic             in_accept;
  logic             in_ready;
  logic [CW-1:0]    col;
  logic [CW-1:0]    last_col;
  logic [FH_W-1:0]  row;
  logic [FH_W-1:0]  last_row;
  lbp_tag_t         tag;
  logic [2*PIX_W-1:0] ls_rd_data;
  logic             ls_wr_en;
  logic [CW-1:0]    ls_wr_addr;
  logic [2*PIX_W-1:0] ls_wr_data;

  assign in_pix.ready = in_ready;
  assign in_accept    = in_pix.valid && in_ready;

  // raster position and geometry
  lbp_pos_ctr #(.MAX_WIDTH(MAX_WIDTH)) u_pos (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .adv       (in_accept),
    .col       (col),
    .last_col  (last_col),
    .row       (row),
    .last_row  (last_row),
    .tag       (tag)
  );

  // two previous rows, read at the incoming column
  lbp_line_store #(.MAX_WIDTH(MAX_WIDTH)) u_ls (
    .clk     (clk),
    .rd_en   (in_accept),
    .rd_addr (col),
    .rd_data (ls_rd_data),
    .wr_en   (ls_wr_en),
    .wr_addr (ls_wr_addr),
    .wr_data (ls_wr_data)
  );

  // window, compare, code register
  lbp_code_stage #(.MAX_WIDTH(MAX_WIDTH)) u_code (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_pix.valid),
    .in_ready     (in_ready),
    .pix_in       (in_pix.brightness),
    .col_in       (col),
    .tag_in       (tag),
    .ls_rd_data   (ls_rd_data),
    .ls_wr_en     (ls_wr_en),
    .ls_wr_addr   (ls_wr_addr),
    .ls_wr_data   (ls_wr_data),
    .out_valid    (out_code.valid),
    .out_ready    (out_code.ready),
    .pattern_code (out_code.pattern_code),
    .frame_end    (out_code.frame_end)
  );

  // line store never reads and writes the same column in one cycle
  a_no_rw_collision: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && ls_wr_en) |-> (col != ls_wr_addr))
    else $error("line store read/write collision");

  // column counter stays inside the active width
  a_col_bound: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> (col <= last_col))
    else $error("column counter beyond frame width");

  // row counter stays inside the active height
  a_row_bound: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> (row <= last_row))
    else $error("row counter beyond frame height");

endmodule
`default_nettype wire

// ===== rtl/core/lbp_line_store.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lbp_line_store: two line stores in one memory
// Entry holds {older row, newer row}; one write and one registered read.
// ----------------------------------------------------------------------------
module lbp_line_store #(
  parameter int MAX_WIDTH = lbp_pkg::DEF_MAX_WIDTH
) (
  input  wire logic                              clk,
  input  wire logic                              rd_en,
  input  wire logic [$clog2(MAX_WIDTH)-1:0]      rd_addr,
  output logic      [2*lbp_pkg::PIX_W-1:0]       rd_data,
  input  wire logic                              wr_en,
  input  wire logic [$clog2(MAX_WIDTH)-1:0]      wr_addr,
  input  wire logic [2*lbp_pkg::PIX_W-1:0]       wr_data
);
  import lbp_pkg::*;

  logic [2*PIX_W-1:0] mem [MAX_WIDTH];
  logic [2*PIX_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read data holds while not enabled
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule
`default_nettype wire

// ===== rtl/core/lbp_pos_ctr.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lbp_pos_ctr: geometry registers and raster position counters
// Holds frame size config, tracks column/row, tags interior centers.
// ----------------------------------------------------------------------------
module lbp_pos_ctr #(
  parameter int MAX_WIDTH = lbp_pkg::DEF_MAX_WIDTH
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              cfg_we,
  input  wire logic [lbp_pkg::CFG_IDX_W-1:0]     cfg_idx,
  input  wire logic [lbp_pkg::CFG_W-1:0]         cfg_wdata,
  input  wire logic                              adv,
  output logic      [$clog2(MAX_WIDTH)-1:0]      col,
  output logic      [$clog2(MAX_WIDTH)-1:0]      last_col,
  output logic      [lbp_pkg::FH_W-1:0]          row,
  output logic      [lbp_pkg::FH_W-1:0]          last_row,
  output lbp_pkg::lbp_tag_t                      tag
);
  import lbp_pkg::*;

  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int WW    = $clog2(MAX_WIDTH + 1);
  localparam int CMP_W = (WW > FW_W) ? WW : FW_W;

  logic [FW_W-1:0]  width_r,  width_nxt;
  logic [FH_W-1:0]  height_r, height_nxt;
  logic [CW-1:0]    col_r,    col_nxt;
  logic [FH_W-1:0]  row_r,    row_nxt;
  logic [CMP_W-1:0] w_ext;
  logic [CMP_W-1:0] w_eff;
  logic             col_wrap;
  logic             row_wrap;

  // clamp width into 3..MAX_WIDTH
  always_comb begin
    w_ext = CMP_W'(width_r);
    if (w_ext < CMP_W'(3)) begin
      w_eff = CMP_W'(3);
    end else if (w_ext > CMP_W'(MAX_WIDTH)) begin
      w_eff = CMP_W'(MAX_WIDTH);
    end else begin
      w_eff = w_ext;
    end
  end

  assign last_col = CW'(w_eff - CMP_W'(1));
  assign last_row = last_row_of(height_r);
  assign col_wrap = (col_r == last_col);
  assign row_wrap = (row_r == last_row);

  always_comb begin
    width_nxt  = width_r;
    height_nxt = height_r;
    col_nxt    = col_r;
    row_nxt    = row_r;
    if (cfg_we) begin
      // any register write restarts the frame
      col_nxt = '0;
      row_nxt = '0;
      case (cfg_reg_t'(cfg_idx))
        CFG_FRAME_WIDTH:  width_nxt  = cfg_wdata[FW_W-1:0];
        CFG_FRAME_HEIGHT: height_nxt = cfg_wdata[FH_W-1:0];
        default: ;
      endcase
    end else if (adv) begin
      if (col_wrap) begin
        col_nxt = '0;
        row_nxt = row_wrap ? '0 : row_r + FH_W'(1);
      end else begin
        col_nxt = col_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= DEF_FRAME_WIDTH;
      height_r <= DEF_FRAME_HEIGHT;
      col_r    <= '0;
      row_r    <= '0;
    end else begin
      width_r  <= width_nxt;
      height_r <= height_nxt;
      col_r    <= col_nxt;
      row_r    <= row_nxt;
    end
  end

  assign col           = col_r;
  assign row           = row_r;
  assign tag.emit      = (row_r >= FH_W'(2)) && (col_r >= CW'(2));
  assign tag.frame_end = col_wrap && row_wrap;

endmodule
`default_nettype wire

// ===== rtl/core/lbp_code_stage.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lbp_code_stage: 3x3 window, neighbor compare and output register
// Stage 1 holds the pixel while line store data arrives; on advance it
// shifts the window, writes line stores, loads the code register if interior.
// ----------------------------------------------------------------------------
module lbp_code_stage #(
  parameter int MAX_WIDTH = lbp_pkg::DEF_MAX_WIDTH
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic [lbp_pkg::PIX_W-1:0]         pix_in,
  input  wire logic [$clog2(MAX_WIDTH)-1:0]      col_in,
  input  wire lbp_pkg::lbp_tag_t                 tag_in,
  input  wire logic [2*lbp_pkg::PIX_W-1:0]       ls_rd_data,
  output logic                                   ls_wr_en,
  output logic      [$clog2(MAX_WIDTH)-1:0]      ls_wr_addr,
  output logic      [2*lbp_pkg::PIX_W-1:0]       ls_wr_data,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic      [lbp_pkg::CODE_W-1:0]        pattern_code,
  output logic                                   frame_end
);
  import lbp_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);

  logic              s1_valid_r, s1_valid_nxt;
  logic [PIX_W-1:0]  s1_pix_r;
  logic [CW-1:0]     s1_col_r;
  lbp_tag_t          s1_tag_r;
  logic [PIX_W-1:0]  win_r [6];
  logic              out_valid_r, out_valid_nxt;
  logic [CODE_W-1:0] code_r;
  logic              fend_r;
  logic              fire;
  logic              take;
  logic [PIX_W-1:0]  p_px;
  logic [PIX_W-1:0]  c_px;
  logic [PIX_W-1:0]  ctr;
  logic [CODE_W-1:0] code_nxt;

  assign fire     = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || fire;
  assign take     = in_valid && in_ready;

  assign p_px = ls_rd_data[2*PIX_W-1:PIX_W];
  assign c_px = ls_rd_data[PIX_W-1:0];
  assign ctr  = win_r[4];

  always_comb begin
    code_nxt[0] = brighter(win_r[1], ctr);
    code_nxt[1] = brighter(win_r[2], ctr);
    code_nxt[2] = brighter(win_r[5], ctr);
    code_nxt[3] = brighter(s1_pix_r, ctr);
    code_nxt[4] = brighter(c_px,     ctr);
    code_nxt[5] = brighter(p_px,     ctr);
    code_nxt[6] = brighter(win_r[3], ctr);
    code_nxt[7] = brighter(win_r[0], ctr);
  end

  always_comb begin
    s1_valid_nxt = take ? 1'b1 : (fire ? 1'b0 : s1_valid_r);
    if (fire && s1_tag_r.emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_pix_r <= pix_in;
      s1_col_r <= col_in;
      s1_tag_r <= tag_in;
    end
    if (fire && s1_tag_r.emit) begin
      code_r <= code_nxt;
      fend_r <= s1_tag_r.frame_end;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 6; i++) begin
        win_r[i] <= '0;
      end
    end else if (fire) begin
      win_r[0] <= win_r[3];
      win_r[1] <= win_r[4];
      win_r[2] <= win_r[5];
      win_r[3] <= p_px;
      win_r[4] <= c_px;
      win_r[5] <= s1_pix_r;
    end
  end

  // column moves down one row: older <- newer, newer <- incoming
  assign ls_wr_en   = fire;
  assign ls_wr_addr = s1_col_r;
  assign ls_wr_data = {c_px, s1_pix_r};

  assign out_valid    = out_valid_r;
  assign pattern_code = code_r;
  assign frame_end    = fend_r;

endmodule
`default_nettype wire

// ===== test/tb_lbp_3x3_pattern_stream.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_lbp_3x3_pattern_stream: self-checking bench for the 3x3 LBP stream
// A directed table runs first: range clamping of both geometry registers,
// a frame restart by a register write, an all-brighter window, a window
// with one equal neighbor, and frame wrap. Random frame geometries follow,
// with one pass at a width above the maximum. Each code transfer is checked
// against a typed row's code or a window model fed with every accepted pixel.
// ----------------------------------------------------------------------------
module tb_lbp_3x3_pattern_stream;
  import lbp_pkg::*;

  localparam int MAXW          = DEF_MAX_WIDTH;
  localparam int CYCLE_LIMIT   = 300000;
  localparam int SETTLE_CYCLES = 8;     // code path is two stages deep
  localparam int RANDOM_PIXELS = 528;

  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic              frame_end;
  } lbp_result_t;

  // One directed step: either a register write or a pixel. A pixel row
  // with typed set carries the code it must produce.
  typedef struct packed {
    logic                 is_write;
    logic [CFG_IDX_W-1:0] reg_idx;
    logic [CFG_W-1:0]     value;
    logic                 typed;
    logic [CODE_W-1:0]    exp_code;
    logic                 exp_end;
  } stim_row_t;

  localparam int N_DIRECTED = 26;
  localparam stim_row_t DIRECTED [N_DIRECTED] = '{
    // width 0 and height 1 both act as 3: 3x3 frame, one code per frame
    '{1'b1, CFG_FRAME_WIDTH,  16'd0, 1'b0, 8'h00, 1'b0},
    '{1'b1, CFG_FRAME_HEIGHT, 16'd1, 1'b0, 8'h00, 1'b0},
    // dark center ringed by full-bright neighbors: every bit set, last code
    '{1'b0, CFG_FRAME_WIDTH, 16'd255, 1'b0, 8'h00, 1'b0},
    '{1'b0, CFG_FRAME_WIDTH, 16'd255, 1'b0, 8'h00, 1'b0},
    '{1'b0, CFG_FRAME_WIDTH, 16'd255, 1'b0, 8'h00, 1'b0},
    '{1'b0, CFG_FRAME_WIDTH, 16'd255, 1'b0, 8'h00, 1'b0},
    '{1'b0, CFG_FRAME_WIDTH, 16'd0,   1'b0, 8'h00, 1'b0},
    '{1'b0, CFG_FRAME_WIDTH, 16'd255, 1'b0, 8'h00, 1'b0},
    '{1'b0, CFG_FRAME_WIDTH, 16'd255, 1'b0, 8'h00, 1'b0},
    '{1'b0, CFG_FRAME_WIDTH, 16'd255, 1'b0, 8'h00, 1'b0},
    '{1'b0, CFG_FRAME_WIDTH, 16'd255, 1'b1, 8'hFF, 1'b1},
    // counters wrapped; abandon this frame after four pixels
    '{1'b0, CFG_FRAME_WIDTH, 16'd7,   1'b0, 8'h00, 1'b0},
    '{1'b0, CFG_FRAME_WIDTH, 16'd250, 1'b0, 8'h00, 1'b0},
    '{1'b0, CFG_FRAME_WIDTH, 16'd0,   1'b0, 8'h00, 1'b0},
    '{1'b0, CFG_FRAME_WIDTH, 16'd128, 1'b0, 8'h00, 1'b0},
    // write restarts at pixel (0,0); width 2 still acts as 3
    '{1'b1, CFG_FRAME_WIDTH,  16'd2, 1'b0, 8'h00, 1'b0},
    // mixed window, one neighbor equal to the center (no bit)
    '{1'b0, CFG_FRAME_WIDTH, 16'd55, 1'b0, 8'h00, 1'b0},
    '{1'b0, CFG_FRAME_WIDTH, 16'd90, 1'b0, 8'h00, 1'b0},
    '{1'b0, CFG_FRAME_WIDTH, 16'd10, 1'b0, 8'h00, 1'b0},
    '{1'b0, CFG_FRAME_WIDTH, 16'd60, 1'b0, 8'h00, 1'b0},
    '{1'b0, CFG_FRAME_WIDTH, 16'd55, 1'b0, 8'h00, 1'b0},
    '{1'b0, CFG_FRAME_WIDTH, 16'd40, 1'b0, 8'h00, 1'b0},
    '{1'b0, CFG_FRAME_WIDTH, 16'd70, 1'b0, 8'h00, 1'b0},
    '{1'b0, CFG_FRAME_WIDTH, 16'd20, 1'b0, 8'h00, 1'b0},
    '{1'b0, CFG_FRAME_WIDTH, 16'd56, 1'b0, 8'h00, 1'b0},
    '{1'b1, CFG_FRAME_HEIGHT, 16'd0, 1'b0, 8'h00, 1'b0}
  };

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_W-1:0]     cfg_wdata;

  lbp_pix_if  pix_if ();
  lbp_code_if code_if ();

  lbp_3x3_pattern_stream i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .in_pix    (pix_if),
    .out_code  (code_if)
  );

  always #5 clk = ~clk;

  // --------------------------------------------------------------------------
  // Window model: two stored rows, 3x2 window of past columns, raster
  // position, geometry registers. Codes it predicts wait in pending_codes.
  // --------------------------------------------------------------------------
  logic [PIX_W-1:0] row_older [MAXW];
  logic [PIX_W-1:0] row_newer [MAXW];
  logic [PIX_W-1:0] win [6];
  int unsigned      col_pos;
  int unsigned      row_pos;
  logic [FW_W-1:0]  width_reg;
  logic [FH_W-1:0]  height_reg;
  lbp_result_t      pending_codes [$];

  int unsigned err_count   = 0;
  int unsigned cycle_count = 0;
  logic        src_stall_en;
  logic        snk_stall_en;

  // width clamps to 3..MAXW, height to at least 3
  function automatic int unsigned frame_cols();
    int unsigned w;
    w = width_reg;
    if (w < 3) w = 3;
    if (w > MAXW) w = MAXW;
    return w;
  endfunction

  function automatic int unsigned frame_rows();
    return (height_reg < 3) ? 3 : height_reg;
  endfunction

  function automatic void clear_window_model();
    for (int i = 0; i < MAXW; i++) begin
      row_older[i] = '0;
      row_newer[i] = '0;
    end
    for (int i = 0; i < 6; i++) win[i] = '0;
    col_pos    = 0;
    row_pos    = 0;
    width_reg  = DEF_FRAME_WIDTH;
    height_reg = DEF_FRAME_HEIGHT;
  endfunction

  // any write restarts the frame
  function automatic void apply_geometry(input logic [CFG_IDX_W-1:0] idx,
                                         input logic [CFG_W-1:0] val);
    if (idx == CFG_FRAME_WIDTH) begin
      width_reg = val[FW_W-1:0];
    end else begin
      height_reg = val[FH_W-1:0];
    end
    col_pos = 0;
    row_pos = 0;
  endfunction

  // Advance the model by one pixel; queue a code when the center is interior.
  function automatic void predict_pixel(input logic [PIX_W-1:0] n, input logic typed,
                                        input lbp_result_t typed_res);
    int unsigned      w;
    int unsigned      h;
    int unsigned      col;
    int unsigned      row;
    logic [PIX_W-1:0] p;
    logic [PIX_W-1:0] c;
    logic [PIX_W-1:0] ctr;
    lbp_result_t      res;
    w   = frame_cols();
    h   = frame_rows();
    col = (col_pos >= w) ? 0 : col_pos;
    row = (row_pos >= h) ? 0 : row_pos;
    p   = row_older[col];
    c   = row_newer[col];
    if (row >= 2 && col >= 2) begin
      // center sits at win[4]; n is below-right of it
      ctr           = win[4];
      res.code      = {win[0] > ctr, win[3] > ctr, p > ctr, c > ctr,
                       n > ctr, win[5] > ctr, win[2] > ctr, win[1] > ctr};
      res.frame_end = (col == w - 1) && (row == h - 1);
      pending_codes.push_back(typed ? typed_res : res);
    end
    win[0] = win[3];
    win[1] = win[4];
    win[2] = win[5];
    win[3] = p;
    win[4] = c;
    win[5] = n;
    row_older[col] = c;
    row_newer[col] = n;
    col++;
    if (col >= w) begin
      col = 0;
      row++;
      if (row >= h) row = 0;
    end
    col_pos = col;
    row_pos = row;
  endfunction

  // mode 1 keeps values close together so equal neighbors are common,
  // mode 2 leans on the two extremes
  function automatic logic [PIX_W-1:0] pick_brightness(input int mode);
    logic [PIX_W-1:0] b;
    b = PIX_W'($urandom_range(0, 255));
    if (mode == 1) begin
      b = PIX_W'($urandom_range(100, 103));
    end else if (mode == 2) begin
      case ($urandom_range(0, 3))
        0: b = '0;
        1: b = '1;
        default: ;
      endcase
    end
    return b;
  endfunction

  // --------------------------------------------------------------------------
  // Pixel source. valid gets one nonblocking update per edge at most: it is
  // either kept high for the next pixel or dropped for a gap.
  // --------------------------------------------------------------------------
  task automatic send_pixel(input logic [PIX_W-1:0] b, input logic typed,
                            input lbp_result_t typed_res);
    if (src_stall_en && $urandom_range(0, 99) < 33) begin
      pix_if.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < 33);
    end
    pix_if.valid      <= 1'b1;
    pix_if.brightness <= b;
    do @(posedge clk); while (!pix_if.ready);
    predict_pixel(b, typed, typed_res);
  endtask

  // Registers change only with the block idle: hold the source, let every
  // queued code drain, then give the pipeline time to flush pixels that
  // produce no code.
  task automatic write_geometry(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_W-1:0] val);
    pix_if.valid <= 1'b0;
    while (pending_codes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    apply_geometry(idx, val);
  endtask

  task automatic send_pixels(input int unsigned count, input int mode);
    for (int unsigned i = 0; i < count; i++) begin
      send_pixel(pick_brightness(mode), 1'b0, '0);
    end
  endtask

  // --------------------------------------------------------------------------
  // Code sink: random back-pressure, and a check on every transfer.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    code_if.ready <= !snk_stall_en || ($urandom_range(0, 99) >= 33);
  end

  always @(posedge clk) begin : code_check
    lbp_result_t want;
    if (rst_n && code_if.valid && code_if.ready) begin
      if (pending_codes.size() == 0) begin
        $error("code transfer with none expected: pattern_code %02h frame_end %0b",
               code_if.pattern_code, code_if.frame_end);
        err_count++;
      end else begin
        want = pending_codes.pop_front();
        if (code_if.pattern_code !== want.code) begin
          $error("pattern_code mismatch: expected %02h, actual %02h",
                 want.code, code_if.pattern_code);
          err_count++;
        end
        if (code_if.frame_end !== want.frame_end) begin
          $error("frame_end mismatch: expected %0b, actual %0b",
                 want.frame_end, code_if.frame_end);
          err_count++;
        end
      end
    end
  end

  // hard stop in case the block hangs
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin : stimulus
    int unsigned sent_random;
    int unsigned phase;
    int unsigned total;
    int unsigned w_val;
    int unsigned h_val;
    int          mode;

    rst_n             = 1'b0;
    cfg_we            = 1'b0;
    cfg_idx           = CFG_FRAME_WIDTH;
    cfg_wdata         = '0;
    pix_if.valid      = 1'b0;
    pix_if.brightness = '0;
    code_if.ready     = 1'b0;
    src_stall_en      = 1'b1;
    snk_stall_en      = 1'b1;
    clear_window_model();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed table
    for (int i = 0; i < N_DIRECTED; i++) begin
      if (DIRECTED[i].is_write) begin
        write_geometry(DIRECTED[i].reg_idx, DIRECTED[i].value);
      end else begin
        send_pixel(DIRECTED[i].value[PIX_W-1:0], DIRECTED[i].typed,
                   '{DIRECTED[i].exp_code, DIRECTED[i].exp_end});
      end
    end

    // random geometries, mostly small frames
    sent_random = 0;
    phase       = 0;
    while (sent_random < RANDOM_PIXELS) begin
      // phase 1 runs with no gaps on either side for a long stretch
      src_stall_en  = ((phase % 5) != 2) && (phase != 1);
      snk_stall_en <= ((phase % 7) != 4) && (phase != 1);

      if (phase == 1) begin
        // width above the maximum clamps; tallest height, partial frame
        write_geometry(CFG_FRAME_WIDTH, CFG_W'(2047));
        write_geometry(CFG_FRAME_HEIGHT, CFG_W'(65535));
        send_pixels(48, 2);
        // narrowest width under the tallest height
        write_geometry(CFG_FRAME_WIDTH, CFG_W'(3));
        send_pixels(36, 1);
        write_geometry(CFG_FRAME_HEIGHT, CFG_W'(3));
        sent_random += 84;
      end

      case ($urandom_range(0, 9))
        0:       w_val = $urandom_range(0, 2);
        1:       w_val = 3;
        default: w_val = $urandom_range(3, 12);
      endcase
      h_val = ($urandom_range(0, 6) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 8);
      if ($urandom_range(0, 1) == 0) begin
        write_geometry(CFG_FRAME_WIDTH, CFG_W'(w_val));
        if ($urandom_range(0, 9) < 7) write_geometry(CFG_FRAME_HEIGHT, CFG_W'(h_val));
      end else begin
        write_geometry(CFG_FRAME_HEIGHT, CFG_W'(h_val));
        if ($urandom_range(0, 9) < 7) write_geometry(CFG_FRAME_WIDTH, CFG_W'(w_val));
      end

      // whole frames, back to back; now and then cut short mid-frame
      total = $urandom_range(1, 3) * frame_cols() * frame_rows();
      if ($urandom_range(0, 4) == 0) total = $urandom_range(1, total);
      if (sent_random >= RANDOM_PIXELS) begin
        total = 1;
      end else if (total > RANDOM_PIXELS - sent_random) begin
        total = RANDOM_PIXELS - sent_random;
      end
      mode = $urandom_range(0, 2);
      send_pixels(total, mode);
      sent_random += total;
      phase++;
    end

    // drain and close out
    pix_if.valid <= 1'b0;
    while (pending_codes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
